/* sv/lzw_pkg.sv */
// Shared constants and types for the LZW encoder.
// No dependencies; used by lzw_cell, lzw_encoder, lzw_checker and tb_lzw_encoder.
package lzw_pkg;

  // Default sizing
  localparam int unsigned DICT_SIZE_DEF     = 4096;
  localparam int unsigned ALPHABET_SIZE_DEF = 26;
  localparam int unsigned LANES_DEF         = 16;

  // Fixed field widths of the stream ports
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned CODE_W       = 12;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 16;

  // Output queue
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = 2;
  localparam int unsigned FIFO_CNT_W   = 3;

  // Control bits of a search token travelling down the cell chain
  typedef struct packed {
    logic valid;  // token carries a row to compare
    logic tail;   // last row of this search
    logic hit;    // some cell upstream matched
  } tok_ctrl_t;

  // One queued result item
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              final_code;
  } res_t;

endpackage

/* sv/lzw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lzw_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lzw_cell.sv */
// One lane of the dictionary search chain: owns every LANES-th entry in a
// private RAM bank and compares it against the token passing through.
// Depends on lzw_pkg and lzw_ram.
module lzw_cell #(
  parameter int unsigned LANE_ID = 0,
  parameter int unsigned LANE_W  = 4,
  parameter int unsigned ROWS    = 256,
  parameter int unsigned ROW_W   = 8,
  parameter int unsigned ENT_W   = 17,
  parameter int unsigned CNT_W   = 13
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // token from upstream neighbor
  input  lzw_pkg::tok_ctrl_t      ctrl_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [ENT_W-1:0]        key_i,
  input  logic [ROW_W+LANE_W-1:0] hidx_i,
  // token to downstream neighbor
  output lzw_pkg::tok_ctrl_t      ctrl_o,
  output logic [ROW_W-1:0]        row_o,
  output logic [ENT_W-1:0]        key_o,
  output logic [ROW_W+LANE_W-1:0] hidx_o,
  // entry insert, broadcast to all lanes
  input  logic                    wr_en_i,
  input  logic [ROW_W-1:0]        wr_row_i,
  input  logic [LANE_W-1:0]       wr_lane_i,
  input  logic [ENT_W-1:0]        wr_data_i,
  // number of entries written so far
  input  logic [CNT_W-1:0]        count_i
);

  lzw_pkg::tok_ctrl_t      ctrl_q;
  logic [ROW_W-1:0]        row_q;
  logic [ENT_W-1:0]        key_q;
  logic [ROW_W+LANE_W-1:0] hidx_q;
  logic [ENT_W-1:0]        rdata;
  logic [ROW_W+LANE_W-1:0] my_idx;
  logic                    ent_valid;
  logic                    match;

  lzw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ROWS)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (wr_en_i && (wr_lane_i == LANE_W'(LANE_ID))),
    .waddr_i (wr_row_i),
    .wdata_i (wr_data_i),
    .raddr_i (row_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_i;
    key_q  <= key_i;
    hidx_q <= hidx_i;
  end

  // read data lines up with the registered token
  assign my_idx    = {row_q, LANE_W'(LANE_ID)};
  assign ent_valid = 32'(my_idx) < 32'(count_i);
  assign match     = ctrl_q.valid && ent_valid && (rdata == key_q);

  assign ctrl_o = '{valid: ctrl_q.valid, tail: ctrl_q.tail, hit: ctrl_q.hit | match};
  assign row_o  = row_q;
  assign key_o  = key_q;
  assign hidx_o = match ? my_idx : hidx_q;

endmodule

/* sv/lzw_encoder.sv */
// LZW encoder top level: phrase control, cell chain search and result queue.
// Depends on lzw_pkg, lzw_cell and lzw_ram.
//
// Takes one letter per item (tlast marks the end of a message) and returns
// phrase codes, tlast on the last code of a message. The dictionary is spread
// over LANES cells, entry j in cell j mod LANES, row j / LANES. A search feeds
// one row per cycle into the head of the chain; each cell compares its entry
// and passes the token on. The first letter of a message opens the phrase;
// any other searches R = max(1, ceil(E / LANES)) rows, E entries written so
// far (up to DICT_SIZE - ALPHABET_SIZE), until the last row leaves the chain,
// and one that ends the message adds a step for the final code. Results wait
// in a 4-item queue; a new item is taken once the search is done and at most
// two results are still waiting. No clearing pass after reset.
module lzw_encoder #(
  parameter int unsigned DICT_SIZE     = lzw_pkg::DICT_SIZE_DEF,
  parameter int unsigned ALPHABET_SIZE = lzw_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned LANES         = lzw_pkg::LANES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lzw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [4:0] letter, rest zero
  input  logic                             s_axis_tlast,   // end_of_message
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lzw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [11:0] code, rest zero
  output logic                             m_axis_tlast    // final_code
);

  localparam int unsigned PH_W    = $clog2(DICT_SIZE);
  localparam int unsigned SYM_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned ENT_W   = PH_W + SYM_W;
  localparam int unsigned NUM_ENT = DICT_SIZE - ALPHABET_SIZE;
  localparam int unsigned CNT_W   = $clog2(NUM_ENT + 1);
  localparam int unsigned LANE_W  = $clog2(LANES);
  localparam int unsigned ROWS    = (NUM_ENT + LANES - 1) / LANES;
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned J_W     = ROW_W + LANE_W;
  localparam int unsigned LETTER_W_T = lzw_pkg::LETTER_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FINAL = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [PH_W-1:0]      phrase_q, phrase_d;
  logic                 active_q, active_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ENT_W-1:0]     key_q, key_d;
  logic [SYM_W-1:0]     sym_q, sym_d;
  logic                 last_q, last_d;
  logic [ROW_W-1:0]     row_ctr_q, row_ctr_d;
  logic [ROW_W-1:0]     last_row_q, last_row_d;
  logic                 hit_seen_q, hit_seen_d;
  logic [J_W-1:0]       hit_idx_q, hit_idx_d;

  // chain wiring
  lzw_pkg::tok_ctrl_t   ch_ctrl [LANES+1];
  logic [ROW_W-1:0]     ch_row  [LANES+1];
  logic [ENT_W-1:0]     ch_key  [LANES+1];
  logic [J_W-1:0]       ch_hidx [LANES+1];

  logic                 wr_en;
  logic [J_W-1:0]       wr_idx;
  logic [J_W-1:0]       cnt_m1;

  // result queue
  lzw_pkg::res_t                  fifo_q [lzw_pkg::FIFO_DEPTH];
  logic [lzw_pkg::FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [lzw_pkg::FIFO_CNT_W-1:0] fcnt_q, fcnt_d;
  logic                           push;
  lzw_pkg::res_t                  push_data;
  logic                           pop;

  logic                 in_acc;
  logic [LETTER_W_T-1:0] letter;
  logic [SYM_W-1:0]     sym;
  logic                 found;
  logic [J_W-1:0]       found_idx;

  assign letter = s_axis_tdata[LETTER_W_T-1:0];
  // letters beyond the alphabet saturate to its last letter
  assign sym = (9'(letter) >= 9'(ALPHABET_SIZE)) ? SYM_W'(ALPHABET_SIZE - 1)
                                                 : SYM_W'(letter);

  assign s_axis_tready = (state_q == S_IDLE) &&
                         (fcnt_q <= lzw_pkg::FIFO_CNT_W'(lzw_pkg::FIFO_DEPTH - 2));
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign cnt_m1 = (count_q == '0) ? '0 : J_W'(count_q - CNT_W'(1));
  assign wr_idx = J_W'(count_q);

  assign found     = hit_seen_q || ch_ctrl[LANES].hit;
  assign found_idx = ch_ctrl[LANES].hit ? ch_hidx[LANES] : hit_idx_q;

  // head of the chain
  assign ch_ctrl[0] = '{valid: (state_q == S_SCAN), tail: (row_ctr_q == last_row_q),
                        hit: 1'b0};
  assign ch_row[0]  = row_ctr_q;
  assign ch_key[0]  = key_q;
  assign ch_hidx[0] = '0;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    lzw_cell #(
      .LANE_ID (g),
      .LANE_W  (LANE_W),
      .ROWS    (ROWS),
      .ROW_W   (ROW_W),
      .ENT_W   (ENT_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ch_ctrl[g]),
      .row_i     (ch_row[g]),
      .key_i     (ch_key[g]),
      .hidx_i    (ch_hidx[g]),
      .ctrl_o    (ch_ctrl[g+1]),
      .row_o     (ch_row[g+1]),
      .key_o     (ch_key[g+1]),
      .hidx_o    (ch_hidx[g+1]),
      .wr_en_i   (wr_en),
      .wr_row_i  (wr_idx[J_W-1:LANE_W]),
      .wr_lane_i (wr_idx[LANE_W-1:0]),
      .wr_data_i ({phrase_q, sym_q}),
      .count_i   (count_q)
    );
  end

  always_comb begin
    state_d    = state_q;
    phrase_d   = phrase_q;
    active_d   = active_q;
    count_d    = count_q;
    key_d      = key_q;
    sym_d      = sym_q;
    last_d     = last_q;
    row_ctr_d  = row_ctr_q;
    last_row_d = last_row_q;
    hit_seen_d = hit_seen_q;
    hit_idx_d  = hit_idx_q;
    wr_en      = 1'b0;
    push       = 1'b0;
    push_data  = '{code: lzw_pkg::CODE_W'(phrase_q), final_code: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!active_q) begin
            // first letter of a message opens the phrase; alone in its message it is also sent as the final code
            phrase_d = PH_W'(sym);
            if (s_axis_tlast) begin
              push      = 1'b1;
              push_data = '{code: lzw_pkg::CODE_W'(sym), final_code: 1'b1};
            end else begin
              active_d = 1'b1;
            end
          end else begin
            key_d      = {phrase_q, sym};
            sym_d      = sym;
            last_d     = s_axis_tlast;
            row_ctr_d  = '0;
            last_row_d = cnt_m1[J_W-1:LANE_W];
            hit_seen_d = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (row_ctr_q == last_row_q) begin
          state_d = S_WAIT;
        end else begin
          row_ctr_d = row_ctr_q + ROW_W'(1);
        end
      end
      S_WAIT: begin
        if (ch_ctrl[LANES].valid && ch_ctrl[LANES].tail) begin
          if (found) begin
            phrase_d = PH_W'(ALPHABET_SIZE) + PH_W'(found_idx);
          end else begin
            push = 1'b1;
            if (count_q != CNT_W'(NUM_ENT)) begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
            phrase_d = PH_W'(sym_q);
          end
          state_d = last_q ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        push      = 1'b1;
        push_data = '{code: lzw_pkg::CODE_W'(phrase_q), final_code: 1'b1};
        active_d  = 1'b0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // collect a hit from any row of the running search
    if (ch_ctrl[LANES].valid && ch_ctrl[LANES].hit) begin
      hit_seen_d = 1'b1;
      hit_idx_d  = ch_hidx[LANES];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phrase_q   <= '0;
      active_q   <= 1'b0;
      count_q    <= '0;
      row_ctr_q  <= '0;
      last_row_q <= '0;
      hit_seen_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      phrase_q   <= phrase_d;
      active_q   <= active_d;
      count_q    <= count_d;
      row_ctr_q  <= row_ctr_d;
      last_row_q <= last_row_d;
      hit_seen_q <= hit_seen_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    sym_q     <= sym_d;
    hit_idx_q <= hit_idx_d;
  end

  // result queue
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign fcnt_d = fcnt_q + lzw_pkg::FIFO_CNT_W'(push) - lzw_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fcnt_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + lzw_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + lzw_pkg::FIFO_PTR_W'(1);
      end
      fcnt_q <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= push_data;
    end
  end

  assign m_axis_tvalid = (fcnt_q != '0);
  assign m_axis_tdata  = {{(lzw_pkg::OUT_TDATA_W - lzw_pkg::CODE_W){1'b0}},
                          fifo_q[rptr_q].code};
  assign m_axis_tlast  = fifo_q[rptr_q].final_code;

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= lzw_pkg::FIFO_CNT_W'(lzw_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fcnt_q != lzw_pkg::FIFO_CNT_W'(lzw_pkg::FIFO_DEPTH)))
    else $error("push into full result queue");

  a_chain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_ctrl[LANES].valid |-> (state_q == S_SCAN || state_q == S_WAIT))
    else $error("search token outside a search");

  a_final_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |-> ($past(state_q) == S_WAIT))
    else $error("final code step not preceded by search end");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(NUM_ENT))
    else $error("dictionary count beyond size");

endmodule

/* tb/lzw_checker.sv */
// Scoreboard for the LZW encoder: watches both stream channels, predicts codes.
// Depends on lzw_pkg; instantiated by tb_lzw_encoder next to the DUT.
module lzw_checker #(
  parameter int unsigned DICT_SIZE     = lzw_pkg::DICT_SIZE_DEF,
  parameter int unsigned ALPHABET_SIZE = lzw_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [lzw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [4:0] letter, rest zero
  input  logic                             s_axis_tlast,   // end_of_message
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [lzw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [11:0] code, rest zero
  input  logic                             m_axis_tlast,   // final_code
  output int unsigned                      mismatches_o,
  output int unsigned                      codes_pending_o,
  output logic                             dict_full_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_W = lzw_pkg::CODE_W + lzw_pkg::LETTER_W;

  // (prefix code, letter) -> code of the extended phrase
  logic [lzw_pkg::CODE_W-1:0] phrase_table [logic [KEY_W-1:0]];
  logic [lzw_pkg::CODE_W:0]   next_code;
  logic [lzw_pkg::CODE_W-1:0] phrase;
  logic                       phrase_open;
  lzw_pkg::res_t              codes_due [$];
  lzw_pkg::res_t              want;

  task automatic emit_code(input logic [lzw_pkg::CODE_W-1:0] code, input logic last);
    lzw_pkg::res_t r;
    r.code       = code;
    r.final_code = last;
    codes_due = {codes_due, r};
  endtask

  task automatic encode_letter(input logic [lzw_pkg::LETTER_W-1:0] raw, input logic eom);
    logic [lzw_pkg::LETTER_W-1:0] sym;
    logic [KEY_W-1:0]             key;
    sym = (raw >= ALPHABET_SIZE) ? lzw_pkg::LETTER_W'(ALPHABET_SIZE - 1) : raw;
    if (!phrase_open) begin
      phrase      = lzw_pkg::CODE_W'(sym);
      phrase_open = 1'b1;
    end else begin
      key = {phrase, sym};
      if (phrase_table.exists(key)) begin
        phrase = phrase_table[key];
      end else begin
        emit_code(phrase, 1'b0);
        if (next_code < DICT_SIZE) begin
          phrase_table[key] = next_code[lzw_pkg::CODE_W-1:0];
          next_code++;
        end
        phrase = lzw_pkg::CODE_W'(sym);
      end
    end
    if (eom) begin
      emit_code(phrase, 1'b1);
      phrase_open = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phrase_table.delete();
      codes_due.delete();
      next_code       = (lzw_pkg::CODE_W + 1)'(ALPHABET_SIZE);
      phrase          = '0;
      phrase_open     = 1'b0;
      mismatches_o    = 0;
      codes_pending_o = 0;
      dict_full_o     = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (codes_due.size() == 0) begin
          $error("code %0d (last %0b) arrived with nothing expected",
                 m_axis_tdata[lzw_pkg::CODE_W-1:0], m_axis_tlast);
          mismatches_o++;
        end else begin
          want = codes_due.pop_front();
          if (m_axis_tdata[lzw_pkg::CODE_W-1:0] !== want.code) begin
            $error("code: expected %0d, got %0d", want.code,
                   m_axis_tdata[lzw_pkg::CODE_W-1:0]);
            mismatches_o++;
          end
          if (m_axis_tlast !== want.final_code) begin
            $error("final_code: expected %0b, got %0b", want.final_code, m_axis_tlast);
            mismatches_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        encode_letter(s_axis_tdata[lzw_pkg::LETTER_W-1:0], s_axis_tlast);
      codes_pending_o = codes_due.size();
      dict_full_o     = (next_code >= DICT_SIZE);
    end
  end

endmodule

/* tb/tb_lzw_encoder.sv */
// Top of the LZW encoder testbench: clock, reset, letter stream and code sink.
// Depends on lzw_pkg, lzw_encoder and lzw_checker.
module tb_lzw_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS  = 420;
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no item moving
  localparam int unsigned SETTLE_CYCLES = 400;   // idle wait before the final report
  localparam int unsigned FILL_CAP      = 130;
  localparam int unsigned PAIRS         = lzw_pkg::ALPHABET_SIZE_DEF *
                                          lzw_pkg::ALPHABET_SIZE_DEF;

  typedef enum int unsigned {
    ANY_SYMBOL,     // whole 5-bit range, out-of-alphabet values included
    ALPHABET,
    THREE_LETTERS,
    TWO_LETTERS
  } text_kind_e;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [lzw_pkg::IN_TDATA_W-1:0]   s_axis_tdata;   // [4:0] letter, rest zero
  logic                             s_axis_tlast;   // end_of_message
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [lzw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;   // [11:0] code, rest zero
  logic                             m_axis_tlast;   // final_code

  int unsigned mismatches;
  int unsigned codes_pending;
  logic        dict_full;
  bit          src_idle;
  bit          snk_idle;
  int unsigned letters_sent;
  int unsigned quiet_cycles = 0;
  int unsigned sink_stall;
  int unsigned fill_next [lzw_pkg::ALPHABET_SIZE_DEF];

  lzw_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lzw_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .mismatches_o    (mismatches),
    .codes_pending_o (codes_pending),
    .dict_full_o     (dict_full)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_letter(input logic [lzw_pkg::LETTER_W-1:0] ltr, input logic eom);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= lzw_pkg::IN_TDATA_W'($urandom);
      s_axis_tlast  <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lzw_pkg::IN_TDATA_W'(ltr);
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    letters_sent++;
  endtask

  // Hold off the sender until every predicted code has come out.
  task automatic drain_codes();
    s_axis_tvalid <= 1'b0;
    wait (codes_pending == 0);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len, input text_kind_e kind);
    logic [lzw_pkg::LETTER_W-1:0] base;
    logic [lzw_pkg::LETTER_W-1:0] ltr;
    base = lzw_pkg::LETTER_W'($urandom_range(0, lzw_pkg::ALPHABET_SIZE_DEF - 3));
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        ANY_SYMBOL:    ltr = lzw_pkg::LETTER_W'($urandom_range(0, 31));
        ALPHABET:      ltr = lzw_pkg::LETTER_W'($urandom_range(0,
                                                 lzw_pkg::ALPHABET_SIZE_DEF - 1));
        THREE_LETTERS: ltr = base + lzw_pkg::LETTER_W'($urandom_range(0, 2));
        default:       ltr = base + lzw_pkg::LETTER_W'($urandom_range(0, 1));
      endcase
      send_letter(ltr, i == len - 1);
    end
  endtask

  // Code sink with its own random stalls
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      sink_stall = snk_idle ? $urandom_range(0, 13) : 0;
      if (sink_stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned prev;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle      = 1'b1;
    snk_idle      = 1'b1;
    letters_sent  = 0;
    foreach (fill_next[k]) fill_next[k] = (k * 97) % PAIRS;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one-letter messages at the alphabet ends
    send_letter(5'd0, 1'b1);
    send_letter(5'd25, 1'b1);
    // "ababab": misses, new entries, then hits on the grown phrase
    for (int unsigned i = 0; i < 6; i++) send_letter(5'(i % 2), i == 5);
    // values past z fold onto z
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b1);
    send_letter(5'd29, 1'b1);
    // one bit at a time through the letter field
    send_letter(5'd16, 1'b0);
    send_letter(5'd8, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd30, 1'b1);
    drain_codes();

    // Random messages, mostly narrow alphabets so phrases grow long
    while (letters_sent < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      len = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0:       send_message(len, ANY_SYMBOL);
        1, 2:    send_message(len, ALPHABET);
        3, 4, 5: send_message(len, THREE_LETTERS);
        default: send_message(len, TWO_LETTERS);
      endcase
      if ($urandom_range(0, 9) == 0) drain_codes();
    end
    drain_codes();

    // Grow the dictionary fast: each step is a known pair followed by a fresh
    // letter, so nearly every second letter adds an entry.
    src_idle = 1'b0;
    snk_idle = 1'b1;
    prev = $urandom_range(0, lzw_pkg::ALPHABET_SIZE_DEF - 1);
    send_letter(5'(prev), 1'b0);
    for (int unsigned step = 0; step < FILL_CAP && !dict_full; step++) begin
      pick = fill_next[prev];
      fill_next[prev] = (pick + 1) % PAIRS;
      send_letter(5'(pick / lzw_pkg::ALPHABET_SIZE_DEF), 1'b0);
      send_letter(5'(pick % lzw_pkg::ALPHABET_SIZE_DEF), 1'b0);
      prev = pick % lzw_pkg::ALPHABET_SIZE_DEF;
    end

    // More messages over the grown dictionary
    src_idle = 1'b1;
    send_message(30, ANY_SYMBOL);
    for (int unsigned i = 0; i < 6; i++) send_message($urandom_range(1, 12), THREE_LETTERS);

    s_axis_tvalid <= 1'b0;
    wait (codes_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
